// File: sv/block_bitmap_allocator_unit_macros.svh
// Assertion macros for the block bitmap allocator checker.
// No dependencies; included by the checker file.
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bba_pkg.sv
// Shared widths, codes and result type for the block bitmap allocator.
// No dependencies.
package bba_pkg;

  // Field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 10;
  localparam int ST_W  = 2;
  localparam int NB_W  = 11;

  // Map storage word and default map size
  localparam int WORD_W          = 32;
  localparam int MAX_BLOCKS_DEF  = 1024;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

  // Configuration register indexes and reset values
  localparam logic REG_NUM_BLOCKS = 1'b0;
  localparam logic REG_RESERVED   = 1'b1;
  localparam logic [NB_W-1:0] NUM_BLOCKS_RST = 11'd1024;
  localparam logic [NB_W-1:0] RESERVED_RST   = 11'd4;

  // Finished command result handed to the output stage
  typedef struct packed {
    logic            push;
    logic [IDX_W-1:0] alloc_block;
    logic [ST_W-1:0]  status;
    logic [NB_W-1:0]  free_count;
  } result_t;

endpackage

// File: sv/block_bitmap_allocator_unit.sv
// Block bitmap allocator: command channel in, one result beat per command.
// Config registers and output stage; uses bba_pkg and bba_seq.
//
// Usage: a command beat (cmd, block_index) is taken on in_valid & in_ready.
// Each command returns exactly one result beat (alloc_block, status,
// free_count) on out_valid & out_ready. Commands are handled one at a time.
// The map lives in a RAM of 32-bit words, one read per cycle; with W words
// (W = 32 at 1024 blocks):
//   allocate: scans up to W words and stops at the first free block in the
//             disk, or reports full at the end of the disk;
//   free:     read, check, write back;
//   format:   writes all W words, one word of the map written per cycle;
//   no-op:    no map access.
// The scan rate is set by the single map read port.
// After reset a clearing pass writes W words while in_ready stays low;
// configuration writes are taken at any time.
// The result sits in an output register: a new command is accepted while
// it waits, and that command stalls at write-back until the slot is free.
module block_bitmap_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_addr,
  input  logic [bba_pkg::NB_W-1:0]  cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bba_pkg::CMD_W-1:0] cmd,
  input  logic [bba_pkg::IDX_W-1:0] block_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bba_pkg::IDX_W-1:0] alloc_block,
  output logic [bba_pkg::ST_W-1:0]  status,
  output logic [bba_pkg::NB_W-1:0]  free_count
);

  logic [bba_pkg::NB_W-1:0] num_blocks;
  logic [bba_pkg::NB_W-1:0] reserved_blocks;
  logic                     out_free;
  bba_pkg::result_t         res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_blocks      <= bba_pkg::NUM_BLOCKS_RST;
      reserved_blocks <= bba_pkg::RESERVED_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == bba_pkg::REG_NUM_BLOCKS) begin
        num_blocks <= cfg_wdata;
      end
      if (cfg_addr == bba_pkg::REG_RESERVED) begin
        reserved_blocks <= cfg_wdata;
      end
    end
  end

  bba_seq #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .num_blocks      (num_blocks),
    .reserved_blocks (reserved_blocks),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .block_index     (block_index),
    .out_free        (out_free),
    .res             (res)
  );

  assign out_free = !out_valid || out_ready;

  // Output register: load on push, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      alloc_block <= res.alloc_block;
      status      <= res.status;
      free_count  <= res.free_count;
    end
  end

endmodule

// File: sv/bba_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies beyond bba_pkg for default sizes.
module bba_ram #(
  parameter int WIDTH = bba_pkg::WORD_W,
  parameter int DEPTH = bba_pkg::MAX_BLOCKS_DEF / bba_pkg::WORD_W
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bba_seq.sv
// Command sequencer of the block bitmap allocator: map RAM, scan, free
// check, format/clear sweep and free-block counter. Uses bba_pkg, bba_ram.
module bba_seq #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [bba_pkg::NB_W-1:0]  num_blocks,
  input  logic [bba_pkg::NB_W-1:0]  reserved_blocks,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [bba_pkg::CMD_W-1:0] cmd,
  input  logic [bba_pkg::IDX_W-1:0] block_index,
  input  logic                      out_free,
  output bba_pkg::result_t          res
);

  localparam int WORD_W = bba_pkg::WORD_W;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int DEPTH  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int POS_W  = ADDR_W + BIT_W;
  localparam int CMP_W  = ((POS_W > bba_pkg::NB_W) ? POS_W : bba_pkg::NB_W) + 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]  MAX_C     = CMP_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_BLOCKS);

  typedef enum logic [5:0] {
    S_CLEAR    = 6'b000001,
    S_IDLE     = 6'b000010,
    S_SCAN     = 6'b000100,
    S_FREE_RD  = 6'b001000,
    S_FREE_CHK = 6'b010000,
    S_COMMIT   = 6'b100000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_fmt;
  logic [ADDR_W-1:0] scan_addr;
  logic [ADDR_W-1:0] chk_addr;
  logic              chk_valid;
  logic [ADDR_W-1:0] idx_word;
  logic [BIT_W-1:0]  idx_bit;
  logic              idx_ok;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [bba_pkg::IDX_W-1:0] r_block;
  logic [bba_pkg::ST_W-1:0]  r_status;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] rd_data;

  logic [CMP_W-1:0]  nb_c;
  logic [CMP_W-1:0]  rb_c;
  logic [CMP_W-1:0]  disk_n;
  logic [CMP_W-1:0]  res_n;
  logic [CMP_W-1:0]  idx_c;
  logic [CMP_W-1:0]  fmt_cnt;
  logic [WORD_W-1:0] disk_mask;
  logic [WORD_W-1:0] free_bits;
  logic              hit;
  logic [BIT_W-1:0]  hit_bit;
  logic              scan_end;

  // Mask of the bits of word addr whose block number lies below lim
  function automatic logic [WORD_W-1:0] word_mask(input logic [ADDR_W-1:0] addr,
                                                  input logic [CMP_W-1:0]  lim);
    logic [CMP_W-1:0]  base;
    logic [CMP_W-1:0]  left;
    logic [WORD_W-1:0] m;
    base = CMP_W'({addr, BIT_W'(0)});
    left = lim - base;
    if (lim <= base) begin
      m = '0;
    end else if (left >= CMP_W'(WORD_W)) begin
      m = '1;
    end else begin
      m = (WORD_W'(1) << left[BIT_W-1:0]) - WORD_W'(1);
    end
    return m;
  endfunction

  // Position of the lowest set bit
  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Effective disk size and reserved span
  always_comb begin
    nb_c    = CMP_W'(num_blocks);
    rb_c    = CMP_W'(reserved_blocks);
    disk_n  = (nb_c > MAX_C) ? MAX_C : nb_c;
    res_n   = (rb_c < disk_n) ? rb_c : disk_n;
    fmt_cnt = (disk_n > rb_c) ? (disk_n - rb_c) : '0;
    idx_c   = CMP_W'(block_index);
  end

  // Evaluate the map word returned by the scan read
  always_comb begin
    disk_mask = word_mask(chk_addr, disk_n);
    free_bits = ~rd_data & disk_mask;
    hit       = |free_bits;
    hit_bit   = first_one(free_bits);
    scan_end  = (disk_mask != '1) || (chk_addr == LAST_ADDR);
  end

  // Map RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = wr_data;
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = clr_fmt ? word_mask(clr_addr, res_n) : '0;
      end
      S_SCAN: begin
        ram_re = 1'b1;
      end
      S_FREE_RD: begin
        ram_re    = idx_ok;
        ram_raddr = idx_word;
      end
      S_COMMIT: begin
        ram_we = wr_pend && out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      clr_fmt   <= 1'b0;
      chk_valid <= 1'b0;
      wr_pend   <= 1'b0;
      cnt       <= '0;
    end else begin
      case (state)
        // Sweep the map: zeros after reset, reserved pattern for format
        S_CLEAR: begin
          if (clr_addr == LAST_ADDR) begin
            clr_addr <= '0;
            state    <= clr_fmt ? S_COMMIT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        // Take one command beat
        S_IDLE: begin
          if (in_valid) begin
            r_block  <= '0;
            r_status <= bba_pkg::ST_OK;
            wr_pend  <= 1'b0;
            case (cmd)
              bba_pkg::CMD_ALLOC: begin
                scan_addr <= '0;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
              bba_pkg::CMD_FREE: begin
                idx_word <= idx_c[BIT_W +: ADDR_W];
                idx_bit  <= block_index[BIT_W-1:0];
                idx_ok   <= idx_c < disk_n;
                state    <= S_FREE_RD;
              end
              bba_pkg::CMD_FORMAT: begin
                clr_addr <= '0;
                clr_fmt  <= 1'b1;
                cnt_next <= CNT_W'(fmt_cnt);
                state    <= S_CLEAR;
              end
              default: begin
                cnt_next <= cnt;
                state    <= S_COMMIT;
              end
            endcase
          end
        end
        // One word read per cycle, each checked in the cycle after its read
        S_SCAN: begin
          if (scan_addr != LAST_ADDR) begin
            scan_addr <= scan_addr + ADDR_W'(1);
          end
          chk_addr  <= scan_addr;
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (hit) begin
              wr_pend  <= 1'b1;
              wr_addr  <= chk_addr;
              wr_data  <= rd_data | (WORD_W'(1) << hit_bit);
              r_block  <= bba_pkg::IDX_W'(CMP_W'({chk_addr, hit_bit}));
              cnt_next <= (cnt == '0) ? '0 : cnt - CNT_W'(1);
              state    <= S_COMMIT;
            end else if (scan_end) begin
              r_status <= bba_pkg::ST_FULL;
              cnt_next <= cnt;
              state    <= S_COMMIT;
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        // Clear an allocated bit or report a bad free
        S_FREE_CHK: begin
          if (idx_ok && rd_data[idx_bit]) begin
            wr_pend  <= 1'b1;
            wr_addr  <= idx_word;
            wr_data  <= rd_data & ~(WORD_W'(1) << idx_bit);
            cnt_next <= (cnt >= MAX_CNT) ? cnt : cnt + CNT_W'(1);
          end else begin
            r_status <= bba_pkg::ST_BADFREE;
            cnt_next <= cnt;
          end
          state <= S_COMMIT;
        end
        // Write back and hand over the result once the output slot is free
        S_COMMIT: begin
          if (out_free) begin
            cnt     <= cnt_next;
            wr_pend <= 1'b0;
            clr_fmt <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready        = (state == S_IDLE);
  assign res.push        = (state == S_COMMIT) && out_free;
  assign res.alloc_block = r_block;
  assign res.status      = r_status;
  assign res.free_count  = bba_pkg::NB_W'(cnt_next);

endmodule

// File: sv/bba_chk.sv
// Port-level checker for the block bitmap allocator, bound to the top level.
// Uses bba_pkg and block_bitmap_allocator_unit_macros.svh.
`include "block_bitmap_allocator_unit_macros.svh"

module bba_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_wr_en,
  input logic                      cfg_addr,
  input logic [bba_pkg::NB_W-1:0]  cfg_wdata,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [bba_pkg::CMD_W-1:0] cmd,
  input logic [bba_pkg::IDX_W-1:0] block_index,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bba_pkg::IDX_W-1:0] alloc_block,
  input logic [bba_pkg::ST_W-1:0]  status,
  input logic [bba_pkg::NB_W-1:0]  free_count
);

  // Hold a stalled result beat
  `BBA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `BBA_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(alloc_block) && $stable(status) && $stable(free_count), "stalled result changed")

  // One command in flight: ready drops after each accepted beat
  `BBA_ASSERT_NEXT(a_one_cmd, clk, rst, in_valid && in_ready, !in_ready, "second command taken while one is in flight")

  // A failed command grants no block
  `BBA_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && (status != bba_pkg::ST_OK), alloc_block == '0, "failed command reports a block")

endmodule

bind block_bitmap_allocator_unit bba_chk u_bba_chk (.*);

// File: test/block_bitmap_allocator_unit_test.sv
// Testbench for block_bitmap_allocator_unit: random and directed allocate/free/format beats,
// with every result beat checked against a shadow allocation map.
// Depends on bba_pkg and the block_bitmap_allocator_unit RTL.
`timescale 1ns / 100ps

module block_bitmap_allocator_unit_test;
  import bba_pkg::*;

  localparam int MAX_BLK        = MAX_BLOCKS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHOW_LIMIT     = 10;

  typedef struct packed {
    logic [CMD_W-1:0] c;
    logic [IDX_W-1:0] idx;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] blk;
    logic [ST_W-1:0]  st;
    logic [NB_W-1:0]  cnt;
  } grant_t;

  // DUT ports
  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             cfg_wr_en   = 1'b0;
  logic             cfg_addr    = REG_NUM_BLOCKS;
  logic [NB_W-1:0]  cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] cmd         = CMD_NOP;
  logic [IDX_W-1:0] block_index = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [IDX_W-1:0] alloc_block;
  logic [ST_W-1:0]  status;
  logic [NB_W-1:0]  free_count;

  // Shadow of the allocator state and its configuration
  bit              shadow_map [MAX_BLK];
  logic [NB_W-1:0] shadow_free = '0;
  logic [NB_W-1:0] cfg_nblk    = NUM_BLOCKS_RST;
  logic [NB_W-1:0] cfg_resv    = RESERVED_RST;

  cmd_item_t cmd_backlog [$];
  grant_t    owed_results [$];

  cmd_item_t nxt_cmd;
  grant_t    want, got;
  logic      in_acc       = 1'b0;
  int        fail_cnt     = 0;
  int        quiet_cycles = 0;
  int        gap_left     = 0;
  int        burst_left   = 1;
  int        rdy_run      = 0;
  int        rdy_mode     = 0;

  block_bitmap_allocator_unit #(
    .MAX_BLOCKS(MAX_BLK)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .block_index(block_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .alloc_block(alloc_block),
    .status     (status),
    .free_count (free_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Effective disk size: saturate at the map size
  function automatic int disk_blocks();
    return (cfg_nblk > MAX_BLK) ? MAX_BLK : int'(cfg_nblk);
  endfunction

  // Apply one command to the shadow map and return the result beat it owes
  task automatic apply_command(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                               output grant_t r);
    int lim;
    int k;
    lim = disk_blocks();
    r = '0;
    case (c)
      CMD_ALLOC: begin
        k = 0;
        while (k < lim && shadow_map[k]) k++;
        if (k < lim) begin
          shadow_map[k] = 1'b1;
          r.blk = k[IDX_W-1:0];
          // counter out of step with the map: hold at zero, no wrap
          if (shadow_free != 0) shadow_free = shadow_free - 1'b1;
        end else begin
          r.st = ST_FULL;
        end
      end
      CMD_FREE: begin
        if (int'(idx) < lim && shadow_map[idx]) begin
          shadow_map[idx] = 1'b0;
          if (shadow_free < MAX_BLK) shadow_free = shadow_free + 1'b1;
        end else begin
          r.st = ST_BADFREE;
        end
      end
      CMD_FORMAT: begin
        for (k = 0; k < MAX_BLK; k++) shadow_map[k] = (k < lim) && (k < int'(cfg_resv));
        shadow_free = (lim > int'(cfg_resv)) ? NB_W'(lim - int'(cfg_resv)) : '0;
      end
      default: begin
      end
    endcase
    r.cnt = shadow_free;
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx);
    cmd_item_t it;
    it.c = c;
    it.idx = idx;
    cmd_backlog.push_back(it);
  endtask

  // Hold until every queued beat is taken and every result beat is back
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers once the block has gone quiet
  task automatic set_config(input logic [NB_W-1:0] nblk, input logic [NB_W-1:0] resv);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_NUM_BLOCKS;
    cfg_wdata <= nblk;
    @(negedge clk);
    cfg_addr  <= REG_RESERVED;
    cfg_wdata <= resv;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_nblk = nblk;
    cfg_resv = resv;
  endtask

  // One configuration, then a mostly well-formed mix of allocates and frees, with formats and no-ops
  task automatic random_phase(input logic [NB_W-1:0] nblk, input logic [NB_W-1:0] resv,
                              input int n_items, input bit fmt_first);
    cmd_item_t it;
    int pick;
    int lim;
    int tries;
    int span;
    int cand;
    set_config(nblk, resv);
    lim = disk_blocks();
    if (fmt_first) queue_cmd(CMD_FORMAT, IDX_W'($urandom));
    repeat (n_items) begin
      while (cmd_backlog.size() >= 2) @(negedge clk);
      pick = $urandom_range(99);
      it.idx = IDX_W'($urandom);
      if (pick < 48) begin
        it.c = CMD_ALLOC;
      end else if (pick < 88) begin
        // aim the free at a block the shadow map holds as used
        it.c = CMD_FREE;
        if (lim > 0) begin
          for (tries = 0; tries < 24; tries++) begin
            span = (tries < 12 && lim > 64) ? 64 : lim;
            cand = $urandom_range(span - 1);
            if (shadow_map[cand]) begin
              it.idx = cand[IDX_W-1:0];
              break;
            end
          end
        end
      end else if (pick < 94) begin
        it.c = CMD_FREE;
      end else if (pick < 97) begin
        it.c = CMD_FORMAT;
      end else begin
        it.c = CMD_NOP;
      end
      cmd_backlog.push_back(it);
    end
  endtask

  // Driver: present command beats in bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt_cmd = cmd_backlog.pop_front();
        in_valid    <= 1'b1;
        cmd         <= nxt_cmd.c;
        block_index <= nxt_cmd.idx;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(12, 1);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: alternate runs of full rate, random stalls and hard stalls
  always @(negedge clk) begin
    if (rdy_run == 0) begin
      rdy_mode = $urandom_range(3);
      rdy_run = $urandom_range(40, 4);
    end
    rdy_run--;
    case (rdy_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(1);
      2:       out_ready <= ($urandom_range(3) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  // Monitor: check result beats, predict on command beats, watch for a hang
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_LIMIT)
          $display("unexpected result beat: blk=%0d st=%0d cnt=%0d",
                   alloc_block, status, free_count);
      end else begin
        want = owed_results.pop_front();
        if (alloc_block !== want.blk || status !== want.st || free_count !== want.cnt) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_LIMIT)
            $display("result mismatch: exp blk=%0d st=%0d cnt=%0d, got blk=%0d st=%0d cnt=%0d",
                     want.blk, want.st, want.cnt, alloc_block, status, free_count);
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      apply_command(cmd, block_index, got);
      owed_results.push_back(got);
    end
    if (!rst && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("block_bitmap_allocator_unit_test: FAIL");
      $finish;
    end
  end

  initial begin
    int k;
    for (k = 0; k < MAX_BLK; k++) shadow_map[k] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults, before any format: counter stays at zero on allocate
    set_config(NUM_BLOCKS_RST, RESERVED_RST);
    queue_cmd(CMD_ALLOC, 10'h3ff);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'd1);
    queue_cmd(CMD_FREE, 10'd1);
    queue_cmd(CMD_FREE, 10'h3ff);
    queue_cmd(CMD_NOP, 10'h155);
    queue_cmd(CMD_FORMAT, 10'h2aa);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'd3);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'h3ff);

    // Empty disk: nothing to grant, every free is bad
    set_config(11'd0, 11'd0);
    queue_cmd(CMD_FORMAT, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'd0);
    queue_cmd(CMD_FREE, 10'h3ff);

    // Oversized disk saturates; everything reserved, then grant the top block
    set_config(11'h7ff, 11'h7ff);
    queue_cmd(CMD_FORMAT, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'h3ff);
    queue_cmd(CMD_ALLOC, 10'h000);

    // Tiny disk: fill it, free beyond the end, free inside
    set_config(11'd3, 11'd1);
    queue_cmd(CMD_FORMAT, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);
    queue_cmd(CMD_FREE, 10'd5);
    queue_cmd(CMD_FREE, 10'd2);

    // Reserved area larger than the disk
    set_config(11'd5, 11'd9);
    queue_cmd(CMD_FORMAT, 10'h000);
    queue_cmd(CMD_ALLOC, 10'h000);

    // Random phases across small, full-size and odd settings
    random_phase(11'd1024, 11'd4, 150, 1'b1);
    random_phase(11'd8, 11'd0, 100, 1'b1);
    random_phase(11'd1, 11'd0, 60, 1'b1);
    random_phase(11'd0, 11'd5, 40, 1'b1);
    random_phase(11'h7ff, 11'd1019, 80, 1'b1);
    random_phase(11'd33, 11'd3, 120, 1'b1);
    random_phase(11'd40, 11'h7ff, 50, 1'b1);
    random_phase(11'd1024, 11'd600, 100, 1'b1);
    random_phase(NB_W'($urandom_range(1024, 1)), NB_W'($urandom_range(64)), 100, 1'b1);
    // no format up front: start from whatever the map holds
    random_phase(NB_W'($urandom_range(200, 1)), NB_W'($urandom_range(2047)), 100, 1'b0);
    random_phase(11'd16, 11'd16, 80, 1'b1);

    // Drain, then allow a last allocate scan before judging
    wait_idle();
    repeat (40) @(negedge clk);
    if (fail_cnt == 0 && owed_results.size() == 0) begin
      $display("block_bitmap_allocator_unit_test: PASS");
    end else begin
      $display("block_bitmap_allocator_unit_test: FAIL");
    end
    $finish;
  end

endmodule
